// ===== hdl/dtt_pkg.sv =====
// Shared types and constants for the deadline timeout table.
// Holds the request and response item layouts and the deadline RAM write port.
// No dependencies.
package dtt_pkg;

	localparam int SLOTS  = 32;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SESS_W = 5;
	localparam int TIME_W = 48;
	localparam int IDLE_W = 16;

	localparam logic [IDLE_W-1:0] IDLE_RESET = IDLE_W'(5000);

	localparam logic ACT_WATCH = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	localparam logic [1:0] KIND_ACK     = 2'd0;
	localparam logic [1:0] KIND_EXPIRED = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	typedef struct packed {
		logic              action;
		logic [SESS_W-1:0] session;
		logic [TIME_W-1:0] time_value;
	} req_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [SESS_W-1:0] expired_session;
		logic [TIME_W-1:0] next_wakeup;
		logic              wake_needed;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		logic [TIME_W-1:0] data;
	} ram_wr_t;

endpackage

// ===== hdl/dtt_deadline_ram.sv =====
// Deadline store: one 48-bit deadline per slot, one write and one read port.
// Read data is registered, so it appears in the cycle after the address.
// Depends on dtt_pkg.
module dtt_deadline_ram (
	input  logic                        clk,
	input  dtt_pkg::ram_wr_t            wr,
	input  logic [dtt_pkg::SLOT_W-1:0]  raddr,
	output logic [dtt_pkg::TIME_W-1:0]  rdata
);
	import dtt_pkg::*;

	logic [TIME_W-1:0] mem [SLOTS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/dtt_ctrl.sv =====
// Sequencer for the deadline timeout table: watch handling, the slot scan,
// valid bits, the held next-wakeup time and the response register.
// Depends on dtt_pkg; drives the deadline RAM in dtt_deadline_ram.
module dtt_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  dtt_pkg::req_t               req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output dtt_pkg::rsp_t               rsp,
	input  logic [dtt_pkg::IDLE_W-1:0]  idle_interval,
	output dtt_pkg::ram_wr_t            ram_wr,
	output logic [dtt_pkg::SLOT_W-1:0]  ram_raddr,
	input  logic [dtt_pkg::TIME_W-1:0]  ram_rdata
);
	import dtt_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_ACK, S_SCAN, S_SUM} state_t;

	state_t            state_q;
	req_t              item_q;
	logic [TIME_W-1:0] nw_q;
	logic [TIME_W-1:0] held_q;
	logic [SLOT_W-1:0] cur_q;
	logic [SLOTS-1:0]  slot_valid_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              accept;
	logic              out_free;
	logic              in_range;
	logic              cur_v;
	logic              cur_exp;
	logic              cur_earlier;
	logic              step;
	logic              last_slot;
	logic              load;
	logic [TIME_W:0]   sum;
	logic [TIME_W-1:0] start_nw;
	rsp_t              rsp_d;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign in_range    = ({1'b0, item_q.session} < (SESS_W+1)'(SLOTS));
	assign cur_v       = slot_valid_q[cur_q];
	assign cur_exp     = cur_v && (ram_rdata <= item_q.time_value);
	assign cur_earlier = cur_v && (ram_rdata < nw_q);
	assign last_slot   = (cur_q == SLOT_W'(SLOTS - 1));
	// An expired slot can only move on once its result has a place to go.
	assign step        = (state_q == S_SCAN) && (!cur_exp || out_free);

	assign sum      = {1'b0, req.time_value} + (TIME_W+1)'(idle_interval);
	assign start_nw = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

	// The read address runs one slot ahead of the slot being judged; it rests
	// on slot zero outside a scan so the first datum is ready when one starts.
	assign ram_raddr = step ? (cur_q + SLOT_W'(1)) : cur_q;

	assign ram_wr.en   = (state_q == S_ACK) && out_free && in_range;
	assign ram_wr.addr = SLOT_W'(item_q.session);
	assign ram_wr.data = item_q.time_value;

	always_comb begin
		rsp_d = '0;
		load  = 1'b0;
		case (state_q)
			S_ACK: begin
				rsp_d.kind        = KIND_ACK;
				rsp_d.wake_needed = in_range && (item_q.time_value < held_q);
				rsp_d.last        = 1'b1;
				load              = out_free;
			end
			S_SCAN: begin
				rsp_d.kind            = KIND_EXPIRED;
				rsp_d.expired_session = SESS_W'(cur_q);
				load                  = cur_exp && out_free;
			end
			S_SUM: begin
				rsp_d.kind        = KIND_SUMMARY;
				rsp_d.next_wakeup = nw_q;
				rsp_d.last        = 1'b1;
				load              = out_free;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			item_q       <= '0;
			nw_q         <= '0;
			held_q       <= '0;
			cur_q        <= '0;
			slot_valid_q <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			if (load) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= rsp_d;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						item_q  <= req;
						nw_q    <= start_nw;
						state_q <= (req.action == ACT_TICK) ? S_SCAN : S_ACK;
					end
				end
				S_ACK: begin
					if (out_free) begin
						if (in_range) begin
							slot_valid_q[SLOT_W'(item_q.session)] <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (step) begin
						if (cur_exp) begin
							slot_valid_q[cur_q] <= 1'b0;
						end else if (cur_earlier) begin
							nw_q <= ram_rdata;
						end
						if (last_slot) begin
							cur_q   <= '0;
							state_q <= S_SUM;
						end else begin
							cur_q <= cur_q + SLOT_W'(1);
						end
					end
				end
				S_SUM: begin
					if (out_free) begin
						held_q  <= nw_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== hdl/deadline_timeout_table.sv =====
// Deadline timeout table: a table of session deadlines scanned on each tick.
//
// Request channel (req_valid, req_stall, req): a watch item writes one slot's
// deadline and gives one acknowledge, with wake_needed set when the deadline
// is earlier than the held next-wakeup time. A tick item carries the current
// time; every valid slot whose deadline is at or before it gives an expired
// result in ascending slot order and is cleared, then a summary gives the next
// wakeup. The last result of each item has last set.
// Response channel (rsp_valid, rsp_stall, rsp): one result per transfer from an
// output register; while the receiver stalls, the result holds and the scan
// pauses on the next expired slot.
// Sequence: a watch passes the ACK state, which loads its acknowledge into the
// output register. A tick scans every slot in the SCAN state, the deadline RAM
// read one slot per cycle unless a stalled receiver holds the scan, then the
// SUM state loads the summary. A new request is taken only once the last result
// of the previous item has been loaded into the output register.
// Configuration (cfg_valid, cfg_ready, cfg_data): writes idle_interval, always
// ready. Reset clears all valid bits and the held wakeup, and sets
// idle_interval to 5000. The deadline RAM itself is not cleared.
module deadline_timeout_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  dtt_pkg::req_t               req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output dtt_pkg::rsp_t               rsp,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [dtt_pkg::IDLE_W-1:0]  cfg_data
);
	import dtt_pkg::*;

	logic [IDLE_W-1:0] idle_q;
	ram_wr_t           ram_wr;
	logic [SLOT_W-1:0] ram_raddr;
	logic [TIME_W-1:0] ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= IDLE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			idle_q <= cfg_data;
		end
	end

	dtt_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.rsp           (rsp),
		.idle_interval (idle_q),
		.ram_wr        (ram_wr),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata)
	);

	dtt_deadline_ram u_ram (
		.clk   (clk),
		.wr    (ram_wr),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

// ===== hdl/dtt_checker.sv =====
// Port checker for the deadline timeout table, attached by a bind statement.
// Depends on dtt_pkg and on the ports of deadline_timeout_table.
module dtt_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input dtt_pkg::rsp_t rsp
);
	import dtt_pkg::*;

	// A stalled result must be held until its transfer.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// Acknowledges and summaries close their item; expired results never do.
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.last == (rsp.kind != KIND_EXPIRED)))
		else $error("last flag does not match result kind");

	a_ack_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_ACK |->
			rsp.expired_session == '0 && rsp.next_wakeup == '0)
		else $error("acknowledge carries scan fields");

	a_expired_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_EXPIRED |->
			rsp.next_wakeup == '0 && !rsp.wake_needed)
		else $error("expired result carries summary fields");

endmodule

bind deadline_timeout_table dtt_checker u_dtt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
